@@ design/bpu_pkg.sv @@
// Shared types and constants of the bitfield pixel unpack unit.
// No dependencies; imported by every module of the unit.
`default_nettype none

package bpu_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    RegRedMask     = 3'd0,
    RegGreenMask   = 3'd1,
    RegBlueMask    = 3'd2,
    RegAlphaMask   = 3'd3,
    RegPixelBits   = 3'd4,
    RegAlphaEnable = 3'd5
  } cfg_reg_e;

  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 32;
  localparam int PixW      = 32;
  localparam int PixBitsW  = 6;
  localparam int ChanW     = 8;

  // default channel masks: 555 for 16 bpp, 888 otherwise
  localparam logic [PixW-1:0] Def16Red   = 32'h0000_7c00;
  localparam logic [PixW-1:0] Def16Green = 32'h0000_03e0;
  localparam logic [PixW-1:0] Def16Blue  = 32'h0000_001f;
  localparam logic [PixW-1:0] Def24Red   = 32'h00ff_0000;
  localparam logic [PixW-1:0] Def24Green = 32'h0000_ff00;
  localparam logic [PixW-1:0] Def24Blue  = 32'h0000_00ff;
  localparam logic [PixBitsW-1:0] PixBits16 = 6'd16;

  // floor(v*255/(2^w-1)) == floor(v*K/2^ScaleShift), K rounded up; exact for v < 128
  localparam int ScaleShift = 16;
  localparam int ScaleMultW = 24;
  localparam int ScaleK1 = (255 * (2 ** ScaleShift) + 0) / 1;
  localparam int ScaleK2 = (255 * (2 ** ScaleShift) + 2) / 3;
  localparam int ScaleK3 = (255 * (2 ** ScaleShift) + 6) / 7;
  localparam int ScaleK4 = (255 * (2 ** ScaleShift) + 14) / 15;
  localparam int ScaleK5 = (255 * (2 ** ScaleShift) + 30) / 31;
  localparam int ScaleK6 = (255 * (2 ** ScaleShift) + 62) / 63;
  localparam int ScaleK7 = (255 * (2 ** ScaleShift) + 126) / 127;

  // per-channel field placement, precomputed from the masks
  typedef struct packed {
    logic       en;   // channel has a nonzero mask
    logic [4:0] lo;   // lowest kept bit of the field
    logic [3:0] w;    // kept width, 1..8
  } chan_setup_t;

  typedef struct packed {
    logic [ChanW-1:0] alpha;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } rgba_t;

  function automatic logic [ScaleMultW-1:0] scale_mult(input logic [3:0] w);
    logic [ScaleMultW-1:0] k;
    case (w)
      4'd1:    k = ScaleMultW'(ScaleK1);
      4'd2:    k = ScaleMultW'(ScaleK2);
      4'd3:    k = ScaleMultW'(ScaleK3);
      4'd4:    k = ScaleMultW'(ScaleK4);
      4'd5:    k = ScaleMultW'(ScaleK5);
      4'd6:    k = ScaleMultW'(ScaleK6);
      4'd7:    k = ScaleMultW'(ScaleK7);
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

@@ design/bpu_chan_setup.sv @@
// Field placement of one channel: lowest kept bit and kept width from a mask.
// Depends on bpu_pkg.
`default_nettype none

module bpu_chan_setup (
  input  logic [31:0]          mask_i,
  output bpu_pkg::chan_setup_t setup_o
);
  import bpu_pkg::*;

  logic [4:0] lo;
  logic [4:0] hi;
  logic [5:0] span;

  always_comb begin
    lo = '0;
    hi = '0;
    for (int i = PixW - 1; i >= 0; i--) begin
      if (mask_i[i]) lo = 5'(i);
    end
    for (int i = 0; i < PixW; i++) begin
      if (mask_i[i]) hi = 5'(i);
    end
    span = {1'b0, hi} - {1'b0, lo} + 6'd1;

    setup_o.en = |mask_i;
    // keep only the top eight bits of a wide field
    if (span > 6'd8) begin
      setup_o.lo = hi - 5'd7;
      setup_o.w  = 4'd8;
    end else begin
      setup_o.lo = lo;
      setup_o.w  = span[3:0];
    end
  end

endmodule

`default_nettype wire

@@ design/bpu_chan_scale.sv @@
// Extract one channel field from a pixel word and scale it to eight bits.
// Depends on bpu_pkg.
`default_nettype none

module bpu_chan_scale (
  input  logic [31:0]          pix_i,
  input  bpu_pkg::chan_setup_t setup_i,
  output logic [7:0]           chan_o
);
  import bpu_pkg::*;

  logic [PixW-1:0]       shifted;
  logic [8:0]            width_ones;
  logic [ChanW-1:0]      field;
  logic [ScaleMultW-1:0] mult;
  logic [30:0]           prod;

  assign shifted    = pix_i >> setup_i.lo;
  assign width_ones = (9'd1 << setup_i.w) - 9'd1;
  assign field      = shifted[ChanW-1:0] & width_ones[ChanW-1:0];
  assign mult       = scale_mult(setup_i.w);
  assign prod       = 31'(field[6:0]) * 31'(mult);

  always_comb begin
    if (!setup_i.en) begin
      chan_o = '0;
    end else if (setup_i.w == 4'd8) begin
      chan_o = field;
    end else begin
      chan_o = prod[ScaleShift +: ChanW];
    end
  end

endmodule

`default_nettype wire

@@ design/bitfield_pixel_unpack_unit.sv @@
// Top level of the bitfield pixel unpack unit: config registers, pipeline, handshakes.
// Depends on bpu_pkg, bpu_chan_setup and bpu_chan_scale.
`default_nettype none

// Unpacks one 16, 24 or 32 bit bitfield pixel word per clock into 8-bit red,
// green, blue and alpha. A word accepted into the input register stays there
// while its fields are extracted and scaled (a shift, a small constant multiply),
// and lands in the output register as soon as that register is free, where its
// result can be taken. The unit accepts a new word every cycle as long as the
// output side keeps up; a stalled output holds the result and lets one more word
// wait in the input register. Channel masks are cut to the pixel width and, when
// red, green and blue are all zero, replaced by the 555 (16 bpp) or 888 defaults.
// Field placement is worked out from the config registers and registered
// alongside them, so write config only while no word is in flight; a word may
// follow in the cycle after the last write.
module bitfield_pixel_unpack_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write port
  input  logic                           cfg_we_i,
  input  logic [bpu_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bpu_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // pixel input
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,   // [31:0] pixel_word
  // unpacked output
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [31:0]                    m_axis_tdata    // [7:0] red_out, [15:8] green_out,
                                                         // [23:16] blue_out, [31:24] alpha_out
);
  import bpu_pkg::*;

  // config registers
  logic [PixW-1:0]     r_mask_q, r_mask_d;
  logic [PixW-1:0]     g_mask_q, g_mask_d;
  logic [PixW-1:0]     b_mask_q, b_mask_d;
  logic [PixW-1:0]     a_mask_q, a_mask_d;
  logic [PixBitsW-1:0] pix_bits_q, pix_bits_d;
  logic                alpha_en_q, alpha_en_d;

  always_comb begin
    r_mask_d   = r_mask_q;
    g_mask_d   = g_mask_q;
    b_mask_d   = b_mask_q;
    a_mask_d   = a_mask_q;
    pix_bits_d = pix_bits_q;
    alpha_en_d = alpha_en_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRedMask:     r_mask_d   = cfg_wdata_i;
        RegGreenMask:   g_mask_d   = cfg_wdata_i;
        RegBlueMask:    b_mask_d   = cfg_wdata_i;
        RegAlphaMask:   a_mask_d   = cfg_wdata_i;
        RegPixelBits:   pix_bits_d = cfg_wdata_i[PixBitsW-1:0];
        RegAlphaEnable: alpha_en_d = cfg_wdata_i[0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_mask_q   <= '0;
      g_mask_q   <= '0;
      b_mask_q   <= '0;
      a_mask_q   <= '0;
      pix_bits_q <= PixBitsW'(32);
      alpha_en_q <= 1'b0;
    end else begin
      r_mask_q   <= r_mask_d;
      g_mask_q   <= g_mask_d;
      b_mask_q   <= b_mask_d;
      a_mask_q   <= a_mask_d;
      pix_bits_q <= pix_bits_d;
      alpha_en_q <= alpha_en_d;
    end
  end

  // Channel setup from the next config values, so the setup registers change
  // on the same edge as the config registers.
  logic [PixW-1:0] cut;
  logic [PixW-1:0] rm_cut, gm_cut, bm_cut, am_cut;
  logic [PixW-1:0] rm_eff, gm_eff, bm_eff;

  always_comb begin
    // keep the low pix_bits bits, or all of them at 32 and above
    cut    = pix_bits_d[5] ? '1 : ~({PixW{1'b1}} << pix_bits_d[4:0]);
    rm_cut = r_mask_d & cut;
    gm_cut = g_mask_d & cut;
    bm_cut = b_mask_d & cut;
    am_cut = a_mask_d & cut;
    if ((rm_cut | gm_cut | bm_cut) == '0) begin
      if (pix_bits_d == PixBits16) begin
        rm_eff = Def16Red & cut;
        gm_eff = Def16Green & cut;
        bm_eff = Def16Blue & cut;
      end else begin
        rm_eff = Def24Red & cut;
        gm_eff = Def24Green & cut;
        bm_eff = Def24Blue & cut;
      end
    end else begin
      rm_eff = rm_cut;
      gm_eff = gm_cut;
      bm_eff = bm_cut;
    end
  end

  chan_setup_t red_set_d, green_set_d, blue_set_d, alpha_raw_set, alpha_set_d;
  chan_setup_t red_set_q, green_set_q, blue_set_q, alpha_set_q;

  bpu_chan_setup u_setup_red   (.mask_i(rm_eff), .setup_o(red_set_d));
  bpu_chan_setup u_setup_green (.mask_i(gm_eff), .setup_o(green_set_d));
  bpu_chan_setup u_setup_blue  (.mask_i(bm_eff), .setup_o(blue_set_d));
  bpu_chan_setup u_setup_alpha (.mask_i(am_cut), .setup_o(alpha_raw_set));

  // a disabled alpha reads as a zero-width channel
  always_comb begin
    alpha_set_d    = alpha_raw_set;
    alpha_set_d.en = alpha_raw_set.en & alpha_en_d;
  end

  // Setup follows config every cycle; the edge after reset loads it from the
  // reset config before any word reaches the scaling stage.
  always_ff @(posedge clk_i) begin
    red_set_q   <= red_set_d;
    green_set_q <= green_set_d;
    blue_set_q  <= blue_set_d;
    alpha_set_q <= alpha_set_d;
  end

  // input register and output register, each with its own valid
  logic            in_valid_q, in_valid_d;
  logic [PixW-1:0] pix_q, pix_d;
  logic            out_valid_q, out_valid_d;
  rgba_t           out_q, out_d;
  rgba_t           rgba;
  logic            out_ready;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_ready;

  bpu_chan_scale u_scale_red   (.pix_i(pix_q), .setup_i(red_set_q),   .chan_o(rgba.red));
  bpu_chan_scale u_scale_green (.pix_i(pix_q), .setup_i(green_set_q), .chan_o(rgba.green));
  bpu_chan_scale u_scale_blue  (.pix_i(pix_q), .setup_i(blue_set_q),  .chan_o(rgba.blue));
  bpu_chan_scale u_scale_alpha (.pix_i(pix_q), .setup_i(alpha_set_q), .chan_o(rgba.alpha));

  always_comb begin
    in_valid_d  = in_valid_q;
    pix_d       = pix_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    // advance the input register whenever it is empty or drains
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
      pix_d      = s_axis_tdata;
    end
    // load the result when the output register is free, else hold it
    if (out_ready) begin
      out_valid_d = in_valid_q;
      out_d       = rgba;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // an empty input register always takes a word
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input not ready with empty input register");

  // an accepted word sits in the input register on the next cycle
  a_accept_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> in_valid_q)
    else $error("accepted word lost");

  // both registers full and output stalled: no further word may enter
  a_full_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready && in_valid_q) |-> !s_axis_tready)
    else $error("word accepted while pipeline full");

  // a result taken with a word waiting is replaced on the next cycle
  a_refill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && in_valid_q) |=> m_axis_tvalid)
    else $error("waiting word not moved to output");

endmodule

`default_nettype wire
